// ----- design/piq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the positional insert queue.
// No dependencies; used by piq_cell and positional_insert_queue.
package piq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_FRONT = 2'd0,
    REQ_BACK  = 2'd1,
    REQ_POS   = 2'd2,
    REQ_POP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the chain for one beat.
  typedef struct packed {
    logic ins;   // open a slot at the insert index
    logic pop;   // move every entry one place to the front
  } shift_ctl_t;

endpackage

// ----- design/piq_cell.sv -----
`timescale 1ns / 1ps
// One slot of the queue chain: holds one identifier and trades it with its neighbors.
// Depends on piq_pkg for the shift control struct.
module piq_cell #(
  parameter int IDX      = 0,
  parameter int CNT_W    = 5,
  parameter int ID_WIDTH = piq_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  piq_pkg::shift_ctl_t ctl,
  input  logic [CNT_W-1:0]    at,
  input  logic [ID_WIDTH-1:0] new_id,
  input  logic [ID_WIDTH-1:0] left,
  input  logic [ID_WIDTH-1:0] right,
  output logic [ID_WIDTH-1:0] data
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      data <= right;
    end else if (ctl.ins) begin
      // cells past the insert index take their front neighbor
      if (MY_IDX > at) begin
        data <= left;
      end else if (MY_IDX == at) begin
        data <= new_id;
      end
    end
  end

endmodule

// ----- design/positional_insert_queue.sv -----
`timescale 1ns / 1ps
// Top level of the positional insert queue: request decode, count and result register.
// Depends on piq_pkg and piq_cell.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  in      | in_valid / in_stall | req_type, item_id, position
//  out     | out_valid/out_stall | status, popped_id, occupancy
//
// For every request, all cells of the chain shift or load in the same edge from a
// broadcast insert index, so one beat is accepted per cycle while in_stall is low.
// The result is registered and shows the cycle after the request beat.
// in_stall is high only while a result waits under out_stall.
// Reset (rst, synchronous) clears the count and the result valid; cell
// contents are left as they are and are only read below the count.
module positional_insert_queue #(
  parameter int CAPACITY = piq_pkg::CAPACITY_DEF,
  parameter int ID_WIDTH = piq_pkg::ID_WIDTH_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [ID_WIDTH-1:0] item_id,
  input  logic [7:0]          position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [ID_WIDTH-1:0] popped_id,
  output logic [CNT_W-1:0]    occupancy
);

  localparam int PW = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    at;
  logic [PW-1:0]       pos_m1;
  logic                accept;
  logic                full;
  logic                empty;
  logic                ins_ok;
  logic                pop_ok;
  piq_pkg::req_t       req;
  piq_pkg::status_t    st_next;
  piq_pkg::shift_ctl_t ctl;
  logic [ID_WIDTH-1:0] data [CAPACITY];

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign req      = piq_pkg::req_t'(req_type);
  assign full     = (count == CAP);
  assign empty    = (count == '0);
  assign ins_ok   = accept & (req != piq_pkg::REQ_POP) & ~full;
  assign pop_ok   = accept & (req == piq_pkg::REQ_POP) & ~empty;
  assign pos_m1   = PW'(position) - PW'(1);

  always_comb begin
    unique case (req)
      piq_pkg::REQ_FRONT: at = '0;
      piq_pkg::REQ_BACK:  at = count;
      piq_pkg::REQ_POS: begin
        // clamp: front for position one or less, append past the end
        if (position <= 8'd1) begin
          at = '0;
        end else if (pos_m1 > PW'(count)) begin
          at = count;
        end else begin
          at = pos_m1[CNT_W-1:0];
        end
      end
      piq_pkg::REQ_POP:   at = '0;
      default:            at = '0;
    endcase
  end

  always_comb begin
    count_next = count;
    st_next    = piq_pkg::ST_OK;
    if (req == piq_pkg::REQ_POP) begin
      if (empty) begin
        st_next = piq_pkg::ST_EMPTY;
      end else begin
        count_next = count - CNT_W'(1);
      end
    end else if (full) begin
      st_next = piq_pkg::ST_FULL;
    end else begin
      count_next = count + CNT_W'(1);
    end
  end

  assign ctl = '{ins: ins_ok, pop: pop_ok};

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ID_WIDTH-1:0] left;
    logic [ID_WIDTH-1:0] right;
    if (k == 0) begin : g_first
      assign left = item_id;
    end else begin : g_mid_l
      assign left = data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[k+1];
    end
    piq_cell #(
      .IDX      (k),
      .CNT_W    (CNT_W),
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .at     (at),
      .new_id (item_id),
      .left   (left),
      .right  (right),
      .data   (data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= st_next;
      popped_id <= pop_ok ? data[0] : '0;
      occupancy <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && (occupancy == count))
    else $error("result missing or occupancy differs from count");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == piq_pkg::ST_EMPTY) |-> (occupancy == '0) && (popped_id == '0))
    else $error("empty status with nonzero fields");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == piq_pkg::ST_FULL) |-> (occupancy == CAP))
    else $error("full status below capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow count");

endmodule
